// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the collision test block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("condition violated");
// A consequence that must hold in the same cycle as its cause.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/barc_pkg.sv =====
// Shared constants and types of the box and ramp collision test block.
package barc_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int NORM_FRAC_DEF   = 14;
	localparam int QUEUE_DEPTH     = 4;
	localparam int NORM_BITS       = 31;
	localparam int SQRT_STEPS      = 32;
	localparam int SQRT_WIDTH      = 64;

	localparam logic FUNC_SLOPE = 1'b1;

	localparam logic [1:0] CORNER_SW = 2'd0;
	localparam logic [1:0] CORNER_NE = 2'd1;
	localparam logic [1:0] CORNER_SE = 2'd2;
	localparam logic [1:0] CORNER_NW = 2'd3;

	localparam logic [1:0] AXIS_NEG_X = 2'd0;
	localparam logic [1:0] AXIS_POS_X = 2'd1;
	localparam logic [1:0] AXIS_NEG_Y = 2'd2;
	localparam logic [1:0] AXIS_POS_Y = 2'd3;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;
endpackage

// ===== sv/barc_ifs.sv =====
// Valid/ready channel interfaces for the query and result items.
interface barc_query_if #(parameter int CW = 32) ();
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic signed [CW-1:0] first_left;
	logic signed [CW-1:0] first_top;
	logic signed [CW-1:0] first_right;
	logic signed [CW-1:0] first_bottom;
	logic signed [CW-1:0] second_left;
	logic signed [CW-1:0] second_top;
	logic signed [CW-1:0] second_right;
	logic signed [CW-1:0] second_bottom;
	logic [1:0]           slope_corner;
	modport source(output valid, func, first_left, first_top, first_right, first_bottom,
		second_left, second_top, second_right, second_bottom, slope_corner, input ready);
	modport sink(input valid, func, first_left, first_top, first_right, first_bottom,
		second_left, second_top, second_right, second_bottom, slope_corner, output ready);
endinterface

interface barc_result_if #(parameter int CW = 32, parameter int NF = 14) ();
	logic                 valid;
	logic                 ready;
	logic                 touching;
	logic signed [CW-1:0] depth;
	logic signed [NF+1:0] push_x;
	logic signed [NF+1:0] push_y;
	modport source(output valid, touching, depth, push_x, push_y, input ready);
	modport sink(input valid, touching, depth, push_x, push_y, output ready);
endinterface

// ===== sv/barc_front.sv =====
// Front end: axis overlap test, least axis penetration and slope operand setup.
module barc_front import barc_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) (
	input  logic                 func,
	input  logic signed [CW-1:0] fl,
	input  logic signed [CW-1:0] ft,
	input  logic signed [CW-1:0] fr,
	input  logic signed [CW-1:0] fb,
	input  logic signed [CW-1:0] sl,
	input  logic signed [CW-1:0] st,
	input  logic signed [CW-1:0] sr,
	input  logic signed [CW-1:0] sb,
	input  logic [1:0]           corner,
	output logic                 hit,
	output logic                 slope,
	output logic signed [CW:0]   axis_depth,
	output logic [1:0]           axis_code,
	output logic                 rx_neg,
	output logic                 ry_neg,
	output logic [CW-1:0]        rx_mag,
	output logic [CW-1:0]        ry_mag,
	output logic signed [CW+1:0] dx,
	output logic signed [CW+1:0] dy
);
	logic                 miss;
	logic signed [CW:0]   d0, d1, d2, d3, w, h;
	logic signed [CW-1:0] px, py, cx, cy;
	logic                 flip_x, flip_y;

	always_comb begin
		miss = (fr < sl) || (fl > sr) || (fb < st) || (ft > sb);
		d0 = (CW+1)'(fr) - (CW+1)'(sl);
		d1 = (CW+1)'(sr) - (CW+1)'(fl);
		d2 = (CW+1)'(fb) - (CW+1)'(st);
		d3 = (CW+1)'(sb) - (CW+1)'(ft);
		// Earlier candidates win ties.
		axis_depth = d0;
		axis_code  = AXIS_NEG_X;
		if (d1 < axis_depth) begin
			axis_depth = d1;
			axis_code  = AXIS_POS_X;
		end
		if (d2 < axis_depth) begin
			axis_depth = d2;
			axis_code  = AXIS_NEG_Y;
		end
		if (d3 < axis_depth) begin
			axis_depth = d3;
			axis_code  = AXIS_POS_Y;
		end

		w = (CW+1)'(sr) - (CW+1)'(sl);
		h = (CW+1)'(sb) - (CW+1)'(st);
		slope = (func == FUNC_SLOPE);
		// A triangle with no extent has no slope normal and never hits.
		hit = !miss && !(slope && (w == '0) && (h == '0));

		unique case (corner)
			CORNER_SW: begin
				px = sr; py = sb; cx = fl; cy = fb; flip_x = 1'b0; flip_y = 1'b1;
			end
			CORNER_NE: begin
				px = sl; py = st; cx = fr; cy = ft; flip_x = 1'b1; flip_y = 1'b0;
			end
			CORNER_SE: begin
				px = sr; py = st; cx = fr; cy = fb; flip_x = 1'b1; flip_y = 1'b1;
			end
			default: begin
				px = sl; py = sb; cx = fl; cy = ft; flip_x = 1'b0; flip_y = 1'b0;
			end
		endcase

		rx_mag = h[CW] ? CW'(-h) : CW'(h);
		ry_mag = w[CW] ? CW'(-w) : CW'(w);
		rx_neg = h[CW] ^ flip_x;
		ry_neg = w[CW] ^ flip_y;
		dx = (CW+2)'(px) - (CW+2)'(cx);
		dy = (CW+2)'(py) - (CW+2)'(cy);
	end
endmodule

// ===== sv/barc_queue.sv =====
// Small FIFO that decouples the front end from the arithmetic back end.
module barc_queue import barc_pkg::*; #(
	parameter int DW    = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	input  logic          pop,
	output logic [DW-1:0] head,
	output queue_stat_t   stat
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DW-1:0] mem [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   count_q;

	assign stat.full  = (count_q == (AW+1)'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== sv/barc_back.sv =====
// Back end: slope normal (normalize, square root, divide), slope depth and result select.
module barc_back import barc_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF,
	parameter int NF = NORM_FRAC_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	output logic                 head_pop,
	input  logic                 hit,
	input  logic                 slope,
	input  logic signed [CW:0]   axis_depth,
	input  logic [1:0]           axis_code,
	input  logic                 rx_neg,
	input  logic                 ry_neg,
	input  logic [CW-1:0]        rx_mag,
	input  logic [CW-1:0]        ry_mag,
	input  logic signed [CW+1:0] dx,
	input  logic signed [CW+1:0] dy,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_touching,
	output logic signed [CW-1:0] out_depth,
	output logic signed [NF+1:0] out_push_x,
	output logic signed [NF+1:0] out_push_y
);
	localparam int PB      = $clog2(CW);
	localparam int NB      = NORM_BITS;
	localparam int SHW     = CW + NB;
	localparam int RW      = SQRT_WIDTH;
	localparam int LW      = 33;
	localparam int QW      = NF + 2;
	localparam int DW      = NF + 34;
	localparam int QSW     = NF + 3;
	localparam int PRW     = QSW + CW + 2;
	localparam int SW      = PRW + 1;
	localparam int PW      = NF + 2;
	localparam int ST_SQ0  = 4;
	localparam int ST_RND  = ST_SQ0 + SQRT_STEPS;
	localparam int ST_NUM  = ST_RND + 1;
	localparam int ST_DIV0 = ST_NUM + 1;
	localparam int ST_MUL  = ST_DIV0 + QW;
	localparam int ST_SUM  = ST_MUL + 1;
	localparam int NST     = ST_SUM + 1;

	localparam logic signed [SW-1:0] HALF   = SW'(1) << (NF - 1);
	localparam logic signed [SW-1:0] SAT_HI = SW'((65'(1) << (CW - 1)) - 65'(1));
	localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);
	localparam logic signed [PW-1:0] ONE    = PW'(1) << NF;

	typedef struct packed {
		logic                 hit;
		logic                 slope;
		logic signed [CW:0]   axis_depth;
		logic [1:0]           axis_code;
		logic                 rx_neg;
		logic                 ry_neg;
		logic signed [CW+1:0] dx;
		logic signed [CW+1:0] dy;
	} ctx_t;

	logic                  en;
	logic                  vld_s  [NST];
	ctx_t                  ctx_s  [NST];
	logic [CW-1:0]         ax_s0, ay_s0;
	logic [PB-1:0]         p_s0;
	logic [NB-1:0]         axn_s  [NST];
	logic [NB-1:0]         ayn_s  [NST];
	logic [2*NB-1:0]       sqx_s2, sqy_s2;
	logic [RW-1:0]         rem_s  [NST];
	logic [RW-1:0]         res_s  [NST];
	logic [LW-1:0]         len_s  [NST];
	logic [DW-1:0]         prtx_s [NST];
	logic [DW-1:0]         prty_s [NST];
	logic [QW-1:0]         qx_s   [NST];
	logic [QW-1:0]         qy_s   [NST];
	logic signed [QSW-1:0] qxs_s  [NST];
	logic signed [QSW-1:0] qys_s  [NST];
	logic signed [PRW-1:0] prx_s, pry_s;
	logic signed [SW-1:0]  sd_s;

	logic [CW-1:0]         mag_max;
	logic [PB-1:0]         lead;
	logic [RW-1:0]         rem_nx [SQRT_STEPS];
	logic [RW-1:0]         res_nx [SQRT_STEPS];
	logic [DW-1:0]         prtx_nx [QW];
	logic [DW-1:0]         prty_nx [QW];
	logic [QW-1:0]         qx_nx  [QW];
	logic [QW-1:0]         qy_nx  [QW];
	logic signed [QSW-1:0] qxs_nx, qys_nx;
	logic signed [SW-1:0]  sd_nx;
	ctx_t                  ctx_in;
	ctx_t                  fin;
	logic                  touch_nx;
	logic signed [SW-1:0]  depth_w;
	logic signed [PW-1:0]  px_nx, py_nx;

	assign en       = !out_valid || out_ready;
	assign head_pop = en && head_valid;

	always_comb begin
		ctx_in.hit        = hit;
		ctx_in.slope      = slope;
		ctx_in.axis_depth = axis_depth;
		ctx_in.axis_code  = axis_code;
		ctx_in.rx_neg     = rx_neg;
		ctx_in.ry_neg     = ry_neg;
		ctx_in.dx         = dx;
		ctx_in.dy         = dy;
	end

	// Position of the leading one of the larger magnitude.
	always_comb begin
		mag_max = (rx_mag > ry_mag) ? rx_mag : ry_mag;
		lead    = '0;
		for (int i = 0; i < CW; i++) begin
			if (mag_max[i]) begin
				lead = PB'(i);
			end
		end
	end

	// One restoring square root step per stage.
	always_comb begin
		logic [RW-1:0] bitv;
		logic [RW-1:0] trial;
		for (int k = 0; k < SQRT_STEPS; k++) begin
			bitv  = RW'(1) << (2 * (SQRT_STEPS - 1 - k));
			trial = res_s[ST_SQ0+k-1] + bitv;
			if (rem_s[ST_SQ0+k-1] >= trial) begin
				rem_nx[k] = rem_s[ST_SQ0+k-1] - trial;
				res_nx[k] = (res_s[ST_SQ0+k-1] >> 1) + bitv;
			end else begin
				rem_nx[k] = rem_s[ST_SQ0+k-1];
				res_nx[k] = res_s[ST_SQ0+k-1] >> 1;
			end
		end
	end

	// One quotient bit per stage for both normal components.
	always_comb begin
		logic [DW-1:0] dvs;
		for (int j = 0; j < QW; j++) begin
			dvs = DW'(len_s[ST_DIV0+j-1]) << (QW - 1 - j);
			prtx_nx[j] = prtx_s[ST_DIV0+j-1];
			qx_nx[j]   = qx_s[ST_DIV0+j-1];
			prty_nx[j] = prty_s[ST_DIV0+j-1];
			qy_nx[j]   = qy_s[ST_DIV0+j-1];
			if (prtx_s[ST_DIV0+j-1] >= dvs) begin
				prtx_nx[j] = prtx_s[ST_DIV0+j-1] - dvs;
				qx_nx[j]   = qx_s[ST_DIV0+j-1] | (QW'(1) << (QW - 1 - j));
			end
			if (prty_s[ST_DIV0+j-1] >= dvs) begin
				prty_nx[j] = prty_s[ST_DIV0+j-1] - dvs;
				qy_nx[j]   = qy_s[ST_DIV0+j-1] | (QW'(1) << (QW - 1 - j));
			end
		end
	end

	always_comb begin
		qxs_nx = ctx_s[ST_MUL-1].rx_neg ? -$signed({1'b0, qx_s[ST_MUL-1]})
			: $signed({1'b0, qx_s[ST_MUL-1]});
		qys_nx = ctx_s[ST_MUL-1].ry_neg ? -$signed({1'b0, qy_s[ST_MUL-1]})
			: $signed({1'b0, qy_s[ST_MUL-1]});
		sd_nx  = (SW'(prx_s) + SW'(pry_s) + HALF) >>> NF;
	end

	// Result select: axis answer, slope answer or a miss.
	always_comb begin
		fin      = ctx_s[ST_SUM];
		touch_nx = 1'b0;
		depth_w  = SW'(fin.axis_depth);
		unique case (fin.axis_code)
			AXIS_NEG_X: begin px_nx = -ONE; py_nx = '0; end
			AXIS_POS_X: begin px_nx = ONE;  py_nx = '0; end
			AXIS_NEG_Y: begin px_nx = '0;   py_nx = -ONE; end
			default:    begin px_nx = '0;   py_nx = ONE; end
		endcase
		if (fin.hit) begin
			touch_nx = 1'b1;
			if (fin.slope) begin
				if (sd_s < 0) begin
					touch_nx = 1'b0;
				end else if (sd_s < depth_w) begin
					depth_w = sd_s;
					px_nx   = PW'(qxs_s[ST_SUM]);
					py_nx   = PW'(qys_s[ST_SUM]);
				end
			end
		end
		if (!touch_nx) begin
			depth_w = '0;
			px_nx   = '0;
			py_nx   = '0;
		end
		if (depth_w > SAT_HI) begin
			depth_w = SAT_HI;
		end else if (depth_w < SAT_LO) begin
			depth_w = SAT_LO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++) begin
				vld_s[i] <= 1'b0;
			end
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s[0] <= head_valid;
			for (int i = 1; i < NST; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
			out_valid <= vld_s[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s[0] <= ctx_in;
			ax_s0    <= rx_mag;
			ay_s0    <= ry_mag;
			p_s0     <= lead;
			for (int i = 1; i < NST; i++) begin
				ctx_s[i] <= ctx_s[i-1];
			end
			// Scale both magnitudes so that the larger has its top bit at NB-1.
			axn_s[1] <= NB'(({ax_s0, NB'(0)} >> 1) >> p_s0);
			ayn_s[1] <= NB'(({ay_s0, NB'(0)} >> 1) >> p_s0);
			for (int i = 2; i < ST_NUM; i++) begin
				axn_s[i] <= axn_s[i-1];
				ayn_s[i] <= ayn_s[i-1];
			end
			sqx_s2   <= (2*NB)'(axn_s[1]) * (2*NB)'(axn_s[1]);
			sqy_s2   <= (2*NB)'(ayn_s[1]) * (2*NB)'(ayn_s[1]);
			rem_s[3] <= RW'(sqx_s2) + RW'(sqy_s2);
			res_s[3] <= '0;
			for (int k = 0; k < SQRT_STEPS; k++) begin
				rem_s[ST_SQ0+k] <= rem_nx[k];
				res_s[ST_SQ0+k] <= res_nx[k];
			end
			len_s[ST_RND] <= LW'(res_s[ST_RND-1])
				+ LW'(rem_s[ST_RND-1] > res_s[ST_RND-1]);
			// The root travels along with the division stages that use it.
			for (int i = ST_RND + 1; i < ST_MUL - 1; i++) begin
				len_s[i] <= len_s[i-1];
			end
			prtx_s[ST_NUM] <= (DW'(axn_s[ST_NUM-1]) << NF) + DW'(len_s[ST_NUM-1] >> 1);
			prty_s[ST_NUM] <= (DW'(ayn_s[ST_NUM-1]) << NF) + DW'(len_s[ST_NUM-1] >> 1);
			qx_s[ST_NUM]   <= '0;
			qy_s[ST_NUM]   <= '0;
			for (int j = 0; j < QW; j++) begin
				prtx_s[ST_DIV0+j] <= prtx_nx[j];
				prty_s[ST_DIV0+j] <= prty_nx[j];
				qx_s[ST_DIV0+j]   <= qx_nx[j];
				qy_s[ST_DIV0+j]   <= qy_nx[j];
			end
			qxs_s[ST_MUL] <= qxs_nx;
			qys_s[ST_MUL] <= qys_nx;
			qxs_s[ST_SUM] <= qxs_s[ST_MUL];
			qys_s[ST_SUM] <= qys_s[ST_MUL];
			prx_s <= PRW'(qxs_nx) * PRW'(ctx_s[ST_MUL-1].dx);
			pry_s <= PRW'(qys_nx) * PRW'(ctx_s[ST_MUL-1].dy);
			sd_s  <= sd_nx;
			out_touching <= touch_nx;
			out_depth    <= CW'(depth_w);
			out_push_x   <= px_nx;
			out_push_y   <= py_nx;
		end
	end
endmodule

// ===== sv/box_and_ramp_collision_test_unit.sv =====
// Top level of the box against box or sloped triangle collision test block.
// Usage:
// The query channel takes one item per cycle while the queue is not full: a moving box and a second shape given by
// its bounding corners, plus the function select and the solid corner of the triangle.
// The result channel returns one item per query, in order: touching, the smallest
// penetration depth (saturated) and the unit push-out normal in Q1.14.
// An accepted item enters a four-entry queue; the front end does the axis tests as the
// item is accepted, and the back end pipeline computes the slope normal and depth.
// The square root takes 32 of the back end pipeline stages and each of the two normal
// dividers NORM_FRAC_BITS + 2 stages, one bit per stage.
// Throughput is one item per cycle while the result side takes items.
// When the receiver stalls, the whole back end pipeline holds; the queue keeps taking
// items until it is full, then query ready drops.
// Reset clears the queue and all pipeline valid flags; no result is pending after it.
`include "assert_macros.svh"
module box_and_ramp_collision_test_unit import barc_pkg::*; #(
	parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
	parameter int NORM_FRAC_BITS = NORM_FRAC_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	barc_query_if.sink     query,
	barc_result_if.source  result
);
	localparam int CW  = COORD_WIDTH;
	// Queue entry: flags, axis depth and code, slope signs, magnitudes and offsets.
	localparam int QDW = 1 + 1 + (CW + 1) + 2 + 1 + 1 + CW + CW + 2 * (CW + 2);

	logic                 f_hit, f_slope, f_rx_neg, f_ry_neg;
	logic signed [CW:0]   f_axis_depth;
	logic [1:0]           f_axis_code;
	logic [CW-1:0]        f_rx_mag, f_ry_mag;
	logic signed [CW+1:0] f_dx, f_dy;

	logic                 b_hit, b_slope, b_rx_neg, b_ry_neg;
	logic signed [CW:0]   b_axis_depth;
	logic [1:0]           b_axis_code;
	logic [CW-1:0]        b_rx_mag, b_ry_mag;
	logic signed [CW+1:0] b_dx, b_dy;

	logic [QDW-1:0]       q_in, q_head;
	logic                 q_push, q_pop;
	queue_stat_t          q_stat;

	// The front end classifies the item in the cycle it is accepted.
	barc_front #(.CW(CW)) u_front (
		.func       (query.func),
		.fl         (query.first_left),
		.ft         (query.first_top),
		.fr         (query.first_right),
		.fb         (query.first_bottom),
		.sl         (query.second_left),
		.st         (query.second_top),
		.sr         (query.second_right),
		.sb         (query.second_bottom),
		.corner     (query.slope_corner),
		.hit        (f_hit),
		.slope      (f_slope),
		.axis_depth (f_axis_depth),
		.axis_code  (f_axis_code),
		.rx_neg     (f_rx_neg),
		.ry_neg     (f_ry_neg),
		.rx_mag     (f_rx_mag),
		.ry_mag     (f_ry_mag),
		.dx         (f_dx),
		.dy         (f_dy)
	);

	assign query.ready = !q_stat.full;
	assign q_push      = query.valid && query.ready;
	assign q_in = {f_hit, f_slope, f_axis_depth, f_axis_code, f_rx_neg, f_ry_neg,
		f_rx_mag, f_ry_mag, f_dx, f_dy};

	barc_queue #(.DW(QDW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	assign {b_hit, b_slope, b_axis_depth, b_axis_code, b_rx_neg, b_ry_neg,
		b_rx_mag, b_ry_mag, b_dx, b_dy} = q_head;

	// The back end drains the queue one item per cycle while the result side moves.
	barc_back #(.CW(CW), .NF(NORM_FRAC_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (!q_stat.empty),
		.head_pop     (q_pop),
		.hit          (b_hit),
		.slope        (b_slope),
		.axis_depth   (b_axis_depth),
		.axis_code    (b_axis_code),
		.rx_neg       (b_rx_neg),
		.ry_neg       (b_ry_neg),
		.rx_mag       (b_rx_mag),
		.ry_mag       (b_ry_mag),
		.dx           (b_dx),
		.dy           (b_dy),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.out_touching (result.touching),
		.out_depth    (result.depth),
		.out_push_x   (result.push_x),
		.out_push_y   (result.push_y)
	);

	// The queue cannot be full and empty at once.
	`ASSERT_ALWAYS(a_queue_state, clk, arst_n, !(q_stat.full && q_stat.empty))
	// A miss carries all-zero result fields.
	`ASSERT_IMPLY(a_miss_zero, clk, arst_n, result.valid && !result.touching, result.depth == '0 && result.push_x == '0 && result.push_y == '0)
	// A hit never reports a negative penetration depth.
	`ASSERT_IMPLY(a_hit_depth, clk, arst_n, result.valid && result.touching, !result.depth[CW-1])
endmodule

// ===== sim/tb.sv =====
// Self-checking testbench of the box and ramp collision test block.
`timescale 1ns / 100ps

module tb import barc_pkg::*; ();

	localparam int CW = 32;
	localparam int NF = 14;
	localparam longint NORMAL_ONE = longint'(1) << NF;
	localparam logic FUNC_BOX = 1'b0;

	typedef struct {
		logic                 func;
		logic signed [CW-1:0] fl, ft, fr, fb;
		logic signed [CW-1:0] sl, st, sr, sb;
		logic [1:0]           corner;
	} query_t;

	typedef struct {
		logic                 touching;
		logic signed [CW-1:0] depth;
		logic signed [NF+1:0] push_x;
		logic signed [NF+1:0] push_y;
	} contact_t;

	typedef struct {
		query_t   q;
		bit       typed;
		contact_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	bit   calm;
	int   errors;

	// Contacts still owed by the block, oldest first.
	contact_t pending_contacts[$];
	stim_row_t stim_rows[$];

	barc_query_if #(.CW(CW)) qry ();
	barc_result_if #(.CW(CW), .NF(NF)) res ();

	box_and_ramp_collision_test_unit dut (
		.clk   (clk),
		.arst_n(arst_n),
		.query (qry),
		.result(res)
	);

	// The clock runs free with a 2 ns period.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// A fixed ceiling on the run far above the slowest legal run.
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	// Rounded integer square root, bit by bit, with a final round to nearest.
	function automatic longint unsigned rounded_root(longint unsigned n);
		longint unsigned root, pos, rem;
		root = 0;
		rem = n;
		pos = longint'(1) << 62;
		while (pos > rem)
			pos = pos >> 2;
		while (pos != 0) begin
			if (rem >= root + pos) begin
				rem = rem - (root + pos);
				root = (root >> 1) + pos;
			end else begin
				root = root >> 1;
			end
			pos = pos >> 2;
		end
		if (rem > root)
			root = root + 1;
		return root;
	endfunction

	// Work out the contact for one query: the axis test first, then the slope
	// test when a triangle is involved.
	function automatic contact_t predict_contact(query_t q);
		contact_t c;
		longint fl, ft, fr, fb, sl, st, sr, sb;
		longint depth, nx, ny, w, h, rx, ry, px, py, cx, cy, qx, qy;
		longint dx, dy, hx, hy, hi, lo, sd;
		longint unsigned ax, ay, m, len;
		c = '{1'b0, '0, '0, '0};
		fl = q.fl; ft = q.ft; fr = q.fr; fb = q.fb;
		sl = q.sl; st = q.st; sr = q.sr; sb = q.sb;
		if (fr < sl || fl > sr || fb < st || ft > sb)
			return c;
		depth = fr - sl; nx = -1; ny = 0;
		if (sr - fl < depth) begin depth = sr - fl; nx = 1; ny = 0; end
		if (fb - st < depth) begin depth = fb - st; nx = 0; ny = -1; end
		if (sb - ft < depth) begin depth = sb - ft; nx = 0; ny = 1; end
		nx = nx * NORMAL_ONE;
		ny = ny * NORMAL_ONE;
		if (q.func == FUNC_SLOPE) begin
			w = sr - sl;
			h = sb - st;
			// A degenerate triangle has no slope direction and never hits.
			if (w == 0 && h == 0)
				return c;
			case (q.corner)
				CORNER_SW: begin rx = h;  ry = -w; px = sr; py = sb; cx = fl; cy = fb; end
				CORNER_NE: begin rx = -h; ry = w;  px = sl; py = st; cx = fr; cy = ft; end
				CORNER_SE: begin rx = -h; ry = -w; px = sr; py = st; cx = fr; cy = fb; end
				default:   begin rx = h;  ry = w;  px = sl; py = sb; cx = fl; cy = ft; end
			endcase
			ax = rx < 0 ? -rx : rx;
			ay = ry < 0 ? -ry : ry;
			m = ax > ay ? ax : ay;
			while (m >= (longint'(1) << 31)) begin m = m >> 1; ax = ax >> 1; ay = ay >> 1; end
			while (m < (longint'(1) << 30)) begin m = m << 1; ax = ax << 1; ay = ay << 1; end
			len = rounded_root(ax * ax + ay * ay);
			qx = ((ax << NF) + (len >> 1)) / len;
			qy = ((ay << NF) + (len >> 1)) / len;
			if (rx < 0) qx = -qx;
			if (ry < 0) qy = -qy;
			dx = px - cx;
			dy = py - cy;
			hx = dx >>> NF;
			hy = dy >>> NF;
			hi = qx * hx + qy * hy;
			lo = qx * (dx - hx * NORMAL_ONE) + qy * (dy - hy * NORMAL_ONE);
			sd = hi + ((lo + (NORMAL_ONE >> 1)) >>> NF);
			if (sd < 0)
				return c;
			if (sd < depth) begin depth = sd; nx = qx; ny = qy; end
		end
		c.touching = 1'b1;
		if (depth > 64'sh7fff_ffff)
			c.depth = 32'sh7fff_ffff;
		else
			c.depth = depth[CW-1:0];
		c.push_x = nx[NF+1:0];
		c.push_y = ny[NF+1:0];
		return c;
	endfunction

	function automatic query_t make_query(logic func, int fl, int ft, int fr, int fb,
		int sl, int st, int sr, int sb, logic [1:0] corner);
		query_t q;
		q = '{func, fl, ft, fr, fb, sl, st, sr, sb, corner};
		return q;
	endfunction

	function automatic contact_t hit(int depth, int px, int py);
		contact_t c;
		c = '{1'b1, depth, px[NF+1:0], py[NF+1:0]};
		return c;
	endfunction

	// Random query: mostly overlapping shapes near a random center, so that the
	// slope test is reached often, plus some fully random coordinates.
	function automatic query_t random_query();
		query_t q;
		int kind, cx, cy, span;
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			q = '{1'($urandom), $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, 2'($urandom)};
			return q;
		end
		span = (kind < 20) ? 'h3fff_ffff : 'h2000;
		cx = $urandom_range(0, 'h20_0000) - 'h10_0000;
		cy = $urandom_range(0, 'h20_0000) - 'h10_0000;
		if (kind < 20) begin
			cx = cx <<< 10;
			cy = cy <<< 10;
		end
		q.func   = $urandom_range(0, 3) != 0;
		q.corner = 2'($urandom);
		q.sl = cx - $urandom_range(0, span);
		q.sr = cx + $urandom_range(0, span);
		q.st = cy - $urandom_range(0, span);
		q.sb = cy + $urandom_range(0, span);
		q.fl = cx + $urandom_range(0, span) - $urandom_range(0, span);
		q.fr = q.fl + $urandom_range(0, span);
		q.ft = cy + $urandom_range(0, span) - $urandom_range(0, span);
		q.fb = q.ft + $urandom_range(0, span);
		// A few malformed boxes with a minimum above the maximum.
		if (kind > 96) begin
			q.fl = q.fr + $urandom_range(1, 64);
		end
		return q;
	endfunction

	// Offer one query item, hold it until accepted, then record what the block
	// owes for it and maybe leave a gap on the sender side.
	task automatic offer_query(query_t q, bit typed, contact_t want);
		qry.valid         <= 1'b1;
		qry.func          <= q.func;
		qry.first_left    <= q.fl;
		qry.first_top     <= q.ft;
		qry.first_right   <= q.fr;
		qry.first_bottom  <= q.fb;
		qry.second_left   <= q.sl;
		qry.second_top    <= q.st;
		qry.second_right  <= q.sr;
		qry.second_bottom <= q.sb;
		qry.slope_corner  <= q.corner;
		do @(posedge clk); while (!qry.ready);
		pending_contacts.push_back(typed ? want : predict_contact(q));
		if (!calm && $urandom_range(0, 4) == 0) begin
			qry.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// Receiver side: ready drops in random bursts until the calm final stretch.
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 7);
			res.ready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// Every result item is matched against the oldest contact still owed.
	always @(posedge clk) begin
		contact_t exp_c;
		if (arst_n && res.valid && res.ready) begin
			if (pending_contacts.size() == 0) begin
				$error("result item with no query outstanding");
				errors++;
			end else begin
				exp_c = pending_contacts.pop_front();
				if (res.touching !== exp_c.touching) begin
					$error("touching: expected %0d, got %0d", exp_c.touching, res.touching);
					errors++;
				end
				if (res.depth !== exp_c.depth) begin
					$error("depth: expected %0d, got %0d", exp_c.depth, res.depth);
					errors++;
				end
				if (res.push_x !== exp_c.push_x) begin
					$error("push_x: expected %0d, got %0d", exp_c.push_x, res.push_x);
					errors++;
				end
				if (res.push_y !== exp_c.push_y) begin
					$error("push_y: expected %0d, got %0d", exp_c.push_y, res.push_y);
					errors++;
				end
			end
		end
	end

	initial begin
		contact_t none;
		int span_min;
		none = '{1'b0, '0, '0, '0};
		span_min = 32'sh8000_0000;
		errors = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		qry.valid         <= 1'b0;
		qry.func          <= 1'b0;
		qry.first_left    <= '0;
		qry.first_top     <= '0;
		qry.first_right   <= '0;
		qry.first_bottom  <= '0;
		qry.second_left   <= '0;
		qry.second_top    <= '0;
		qry.second_right  <= '0;
		qry.second_bottom <= '0;
		qry.slope_corner  <= '0;

		// Directed rows. Results that are plain from the geometry are typed in;
		// the other slope rows and the malformed boxes are left to the predictor.
		// Overlap on x is the shallowest, so the push goes toward minus x.
		stim_rows.push_back('{make_query(FUNC_BOX, 0, 0, 256, 256, 128, 0, 384, 256, CORNER_SW),
			1'b1, hit(128, -16384, 0)});
		// Same query with a corner code set; a box pair ignores it.
		stim_rows.push_back('{make_query(FUNC_BOX, 0, 0, 256, 256, 128, 0, 384, 256, CORNER_NW),
			1'b1, hit(128, -16384, 0)});
		// Separated on x, then on y.
		stim_rows.push_back('{make_query(FUNC_BOX, 0, 0, 100, 100, 101, 0, 300, 100, CORNER_SW),
			1'b1, none});
		stim_rows.push_back('{make_query(FUNC_BOX, 0, 301, 100, 400, 0, 0, 100, 300, CORNER_SW),
			1'b1, none});
		// Edges just meet: a hit with zero depth.
		stim_rows.push_back('{make_query(FUNC_BOX, 0, 0, 256, 256, 256, 0, 512, 256, CORNER_SW),
			1'b1, hit(0, -16384, 0)});
		// Identical boxes: all four overlaps tie and the first one wins.
		stim_rows.push_back('{make_query(FUNC_BOX, 0, 0, 256, 256, 0, 0, 256, 256, CORNER_SW),
			1'b1, hit(256, -16384, 0)});
		// Full range on both shapes: the depth saturates.
		stim_rows.push_back('{make_query(FUNC_BOX, span_min, span_min, 'h7fff_ffff, 'h7fff_ffff,
			span_min, span_min, 'h7fff_ffff, 'h7fff_ffff, CORNER_SW),
			1'b1, hit('h7fff_ffff, -16384, 0)});
		// A triangle of zero size never reports a hit.
		stim_rows.push_back('{make_query(FUNC_SLOPE, 0, 0, 1024, 1024, 512, 512, 512, 512,
			CORNER_SW), 1'b1, none});
		// The four slope directions on one triangle.
		stim_rows.push_back('{make_query(FUNC_SLOPE, 0, 0, 1024, 1024, 512, 256, 2048, 1536,
			CORNER_SW), 1'b0, none});
		stim_rows.push_back('{make_query(FUNC_SLOPE, 0, 0, 1024, 1024, 512, 256, 2048, 1536,
			CORNER_NE), 1'b0, none});
		stim_rows.push_back('{make_query(FUNC_SLOPE, 0, 0, 1024, 1024, 512, 256, 2048, 1536,
			CORNER_SE), 1'b0, none});
		stim_rows.push_back('{make_query(FUNC_SLOPE, 0, 0, 1024, 1024, 512, 256, 2048, 1536,
			CORNER_NW), 1'b0, none});
		// A full-range triangle, where the raw normal must be scaled down.
		stim_rows.push_back('{make_query(FUNC_SLOPE, -512, -512, 512, 512, span_min, span_min,
			'h7fff_ffff, 'h7fff_ffff, CORNER_NE), 1'b0, none});
		stim_rows.push_back('{make_query(FUNC_SLOPE, span_min, span_min, span_min + 4096,
			span_min + 4096, span_min, span_min, span_min + 8192, span_min + 2048, CORNER_SE),
			1'b0, none});
		// Triangles flat in one direction.
		stim_rows.push_back('{make_query(FUNC_SLOPE, 0, 0, 512, 512, 256, 0, 256, 2048,
			CORNER_SW), 1'b0, none});
		stim_rows.push_back('{make_query(FUNC_SLOPE, 0, 0, 512, 512, 0, 256, 2048, 256,
			CORNER_NW), 1'b0, none});
		// Box inside the bounding box but on the open side of the slope.
		stim_rows.push_back('{make_query(FUNC_SLOPE, 3800, 0, 4096, 300, 0, 0, 4096, 4096,
			CORNER_SW), 1'b0, none});
		// Malformed moving box, minimum above maximum.
		stim_rows.push_back('{make_query(FUNC_BOX, 1024, 0, 0, 512, 0, 0, 512, 512, CORNER_SW),
			1'b0, none});
		stim_rows.push_back('{make_query(FUNC_SLOPE, 600, 0, 100, 512, 0, 0, 512, 512,
			CORNER_NE), 1'b0, none});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i])
			offer_query(stim_rows[i].q, stim_rows[i].typed, stim_rows[i].want);

		// Let the sender stand still until every owed result has drained.
		qry.valid <= 1'b0;
		while (pending_contacts.size() != 0)
			@(posedge clk);

		for (int n = 0; n < 750; n++) begin
			if (n == 650)
				calm = 1'b1;
			offer_query(random_query(), 1'b0, none);
		end
		qry.valid <= 1'b0;

		while (pending_contacts.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
